FILE: hw/rtl/tprp_pkg.sv
// Shared types and constants for the turtle pen raster plotter.
`timescale 1ns / 1ps

package tprp_pkg;

   // Field widths of the command and row transactions.
   localparam int KIND_W = 3;
   localparam int DIST_W = 8;
   localparam int POS_W  = 5;
   localparam int BITS_W = 32;
   localparam int CNT_W  = POS_W + 1;

   // Command codes.
   localparam logic [KIND_W-1:0] KIND_PEN_UP    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PEN_DOWN  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TURN_RGT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TURN_LFT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PRINT     = 3'd5;

   // Heading codes; a right turn adds one, a left turn adds three.
   localparam logic [1:0] HEAD_RIGHT = 2'd0;
   localparam logic [1:0] HEAD_DOWN  = 2'd1;
   localparam logic [1:0] HEAD_LEFT  = 2'd2;
   localparam logic [1:0] HEAD_UP    = 2'd3;
   localparam logic [1:0] HEAD_TURN_LFT = 2'd3;

   // Canvas read request.
   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
   } tprp_rd_req_type;

   // Canvas write request.
   typedef struct packed {
      logic              en;
      logic [POS_W-1:0]  addr;
      logic [BITS_W-1:0] data;
   } tprp_wr_req_type;

   // Word with every bit below position n set (n from 0 to BITS_W).
   function automatic logic [BITS_W-1:0] ones_below(input logic [CNT_W-1:0] n);
      logic [BITS_W:0] full;
      full = ({{BITS_W{1'b0}}, 1'b1} << n) - {{BITS_W{1'b0}}, 1'b1};
      return full[BITS_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/turtle_pen_raster_plotter.sv
// Top level of the turtle pen raster plotter: command sequencer and row output.
`timescale 1ns / 1ps
//
// Usage:
// - Commands arrive on the req_ channel (req_kind, req_distance). A transaction
//   completes on a clock edge with req_valid high and req_stall low.
// - Pen and turn commands and a move with the pen up leave the sequencer idle.
//   A horizontal move with the pen down reads the row, then writes it back. A
//   vertical move with the pen down reads one canvas row per cycle while the
//   previous one is written.
// - Print streams GRID_N row transactions on the rsp_ channel, top row first,
//   with rsp_last_row set on the final one. The canvas read port delivers one
//   row per cycle unless rsp_stall holds the output.
// - The row output is registered, so the next command is taken while the last
//   row still waits. rsp_stall holds the output row and pauses canvas reads.
// - Reset clears the pen (up), heading (right), position (top left corner) and
//   the per-row valid bits, which makes the whole canvas read as blank at once.
// - The grid in use is GRID_SIZE limited to the range 2 to 32.

module turtle_pen_raster_plotter #(
   parameter int GRID_SIZE = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tprp_pkg::KIND_W-1:0]    req_kind,
   input  logic [tprp_pkg::DIST_W-1:0]    req_distance,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tprp_pkg::POS_W-1:0]     rsp_row_index,
   output logic [tprp_pkg::BITS_W-1:0]    rsp_row_bits,
   output logic                           rsp_last_row
);
   import tprp_pkg::*;

   localparam int GRID_N = (GRID_SIZE > 32) ? 32 : ((GRID_SIZE < 2) ? 2 : GRID_SIZE);
   localparam logic [POS_W-1:0] GRID_LAST = POS_W'(GRID_N - 1);
   localparam logic [CNT_W-1:0] ROW_COUNT = CNT_W'(GRID_N);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_HWR   = 2'd1;
   localparam logic [1:0] ST_VWALK = 2'd2;
   localparam logic [1:0] ST_PRINT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic              pen_ff, pen_in;
   logic [1:0]        heading_ff, heading_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  walk_row_ff, walk_row_in;
   logic              walk_up_ff, walk_up_in;
   logic [POS_W-1:0]  cnt_ff, cnt_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [POS_W-1:0]  wr_row_ff, wr_row_in;
   logic [BITS_W-1:0] wr_mask_ff, wr_mask_in;
   logic [CNT_W-1:0]  prow_ff, prow_in;
   logic              avail_ff, avail_in;
   logic [POS_W-1:0]  avail_row_ff, avail_row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_row_index_ff;
   logic [BITS_W-1:0] rsp_row_bits_ff;
   logic              rsp_last_row_ff;

   tprp_rd_req_type   rd_req;
   tprp_wr_req_type   wr_req;
   logic [BITS_W-1:0] rd_data;

   logic              accept;
   logic [POS_W-1:0]  room;
   logic [POS_W-1:0]  steps;
   logic [CNT_W-1:0]  h_lo;
   logic [CNT_W-1:0]  h_hi1;
   logic [BITS_W-1:0] h_mask;
   logic              load;
   logic              issue;

   tprp_canvas #(
      .DEPTH (GRID_N)
   ) u_canvas (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .wr_req  (wr_req),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Room to the grid edge in the current heading, and the clamped step count.
   always_comb begin
      unique case (heading_ff)
         HEAD_RIGHT: room = GRID_LAST - col_ff;
         HEAD_DOWN:  room = GRID_LAST - row_ff;
         HEAD_LEFT:  room = col_ff;
         HEAD_UP:    room = row_ff;
      endcase
      steps = (req_distance < {{(DIST_W - POS_W){1'b0}}, room}) ?
              req_distance[POS_W-1:0] : room;
   end

   // Columns entered by a horizontal move, as a span mask of the row word.
   always_comb begin
      if (heading_ff == HEAD_RIGHT) begin
         h_lo  = {1'b0, col_ff} + CNT_W'(1);
         h_hi1 = {1'b0, col_ff} + {1'b0, steps} + CNT_W'(1);
      end else begin
         h_lo  = {1'b0, col_ff} - {1'b0, steps};
         h_hi1 = {1'b0, col_ff};
      end
      h_mask = ones_below(h_hi1) & ~ones_below(h_lo);
   end

   // Print flow: load a fetched row when the output is free, fetch ahead.
   assign load  = (state_ff == ST_PRINT) && avail_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue = (state_ff == ST_PRINT) && (prow_ff != ROW_COUNT) && (!avail_ff || load);

   // Command sequencer and canvas read-modify-write control.
   always_comb begin
      state_in     = state_ff;
      pen_in       = pen_ff;
      heading_in   = heading_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      walk_row_in  = walk_row_ff;
      walk_up_in   = walk_up_ff;
      cnt_in       = cnt_ff;
      wr_pend_in   = wr_pend_ff;
      wr_row_in    = wr_row_ff;
      wr_mask_in   = wr_mask_ff;
      prow_in      = prow_ff;
      avail_in     = avail_ff;
      avail_row_in = avail_row_ff;
      rd_req       = '0;
      wr_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_PEN_UP:   pen_in = 1'b0;
                  KIND_PEN_DOWN: pen_in = 1'b1;
                  KIND_TURN_RGT: heading_in = heading_ff + 2'd1;
                  KIND_TURN_LFT: heading_in = heading_ff + HEAD_TURN_LFT;
                  KIND_MOVE: begin
                     unique case (heading_ff)
                        HEAD_RIGHT: col_in = col_ff + steps;
                        HEAD_DOWN:  row_in = row_ff + steps;
                        HEAD_LEFT:  col_in = col_ff - steps;
                        HEAD_UP:    row_in = row_ff - steps;
                     endcase
                     if (pen_ff && (steps != '0)) begin
                        if (!heading_ff[0]) begin
                           // Horizontal: all marks land in the current row.
                           rd_req.en   = 1'b1;
                           rd_req.addr = row_ff;
                           wr_row_in   = row_ff;
                           wr_mask_in  = h_mask;
                           state_in    = ST_HWR;
                        end else begin
                           // Vertical: one row per step, one column bit.
                           walk_up_in  = (heading_ff == HEAD_UP);
                           walk_row_in = (heading_ff == HEAD_UP) ? row_ff - POS_W'(1) :
                                                                   row_ff + POS_W'(1);
                           cnt_in      = steps;
                           wr_pend_in  = 1'b0;
                           wr_mask_in  = ones_below({1'b0, col_ff} + CNT_W'(1)) &
                                         ~ones_below({1'b0, col_ff});
                           state_in    = ST_VWALK;
                        end
                     end
                  end
                  KIND_PRINT: begin
                     prow_in  = '0;
                     avail_in = 1'b0;
                     state_in = ST_PRINT;
                  end
                  default: ;
               endcase
            end
         end

         ST_HWR: begin
            wr_req.en   = 1'b1;
            wr_req.addr = wr_row_ff;
            wr_req.data = rd_data | wr_mask_ff;
            state_in    = ST_IDLE;
         end

         ST_VWALK: begin
            // Write back the row read last cycle while reading the next one.
            if (wr_pend_ff) begin
               wr_req.en   = 1'b1;
               wr_req.addr = wr_row_ff;
               wr_req.data = rd_data | wr_mask_ff;
            end
            if (cnt_ff != '0) begin
               rd_req.en   = 1'b1;
               rd_req.addr = walk_row_ff;
               wr_row_in   = walk_row_ff;
               wr_pend_in  = 1'b1;
               walk_row_in = walk_up_ff ? walk_row_ff - POS_W'(1) : walk_row_ff + POS_W'(1);
               cnt_in      = cnt_ff - POS_W'(1);
            end else begin
               wr_pend_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end

         ST_PRINT: begin
            if (issue) begin
               rd_req.en    = 1'b1;
               rd_req.addr  = prow_ff[POS_W-1:0];
               prow_in      = prow_ff + CNT_W'(1);
               avail_row_in = prow_ff[POS_W-1:0];
               avail_in     = 1'b1;
            end else if (load) begin
               avail_in = 1'b0;
            end
            if ((prow_ff == ROW_COUNT) && !avail_ff) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_ff       <= 1'b0;
         heading_ff   <= HEAD_RIGHT;
         row_ff       <= '0;
         col_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         avail_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_ff       <= pen_in;
         heading_ff   <= heading_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         wr_pend_ff   <= wr_pend_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the move and print sequences.
   always_ff @(posedge clock) begin
      walk_row_ff  <= walk_row_in;
      walk_up_ff   <= walk_up_in;
      cnt_ff       <= cnt_in;
      wr_row_ff    <= wr_row_in;
      wr_mask_ff   <= wr_mask_in;
      prow_ff      <= prow_in;
      avail_row_ff <= avail_row_in;
   end

   // Output row register, loaded only when the previous transaction is gone.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_row_index_ff <= avail_row_ff;
         rsp_row_bits_ff  <= rd_data;
         rsp_last_row_ff  <= (avail_row_ff == GRID_LAST);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_row_bits  = rsp_row_bits_ff;
   assign rsp_last_row  = rsp_last_row_ff;

   // A write back never targets the row being read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (wr_req.en && rd_req.en) |-> (wr_req.addr != rd_req.addr))
      else $error("canvas read and write collide on one row");

   // Canvas writes only come from the two move sequences.
   assert property (@(posedge clock) disable iff (reset)
      wr_req.en |-> ((state_ff == ST_HWR) || (state_ff == ST_VWALK)))
      else $error("canvas write outside a move");

   // The last-row flag marks the bottom grid row only.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_row_ff) |-> (rsp_row_index_ff == GRID_LAST))
      else $error("last row flag on a row other than the bottom one");

   // A vertical walk with no steps left finishes in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_VWALK) && (cnt_ff == '0)) |=> (state_ff == ST_IDLE))
      else $error("vertical walk did not finish");

endmodule

FILE: hw/rtl/tprp_canvas.sv
// Canvas memory: one row word per entry, synchronous read, per-row valid bits.
`timescale 1ns / 1ps

module tprp_canvas #(
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tprp_pkg::tprp_rd_req_type        rd_req,
   input  tprp_pkg::tprp_wr_req_type        wr_req,
   output logic [tprp_pkg::BITS_W-1:0]      rd_data
);
   import tprp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [BITS_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [BITS_W-1:0] rd_data_ff;

   // Row storage; contents carry no reset.
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr[AW-1:0]] <= wr_req.data;
      end
   end

   // A row that was never written reads as blank.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_req.en) begin
         valid_ff[wr_req.addr[AW-1:0]] <= 1'b1;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= valid_ff[rd_req.addr[AW-1:0]] ? mem[rd_req.addr[AW-1:0]] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/sv/turtle_pen_plot_checker.sv
// Checker that predicts the plotter's row transactions and compares them with the DUT output.
`timescale 1ns / 1ps

module turtle_pen_plot_checker #(
   parameter int GRID_SIZE = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [tprp_pkg::KIND_W-1:0]    req_kind,
   input  logic [tprp_pkg::DIST_W-1:0]    req_distance,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [tprp_pkg::POS_W-1:0]     rsp_row_index,
   input  logic [tprp_pkg::BITS_W-1:0]    rsp_row_bits,
   input  logic                           rsp_last_row,
   output int                             mismatch_count,
   output int                             rows_pending
);

   import tprp_pkg::*;

   // The grid in use is the parameter limited to 2..32.
   localparam int GRID_N = (GRID_SIZE > 32) ? 32 : ((GRID_SIZE < 2) ? 2 : GRID_SIZE);

   typedef struct packed {
      logic [POS_W-1:0]  row_index;
      logic [BITS_W-1:0] row_bits;
      logic              last_row;
   } row_word_type;

   // Predicted plotter state and the rows still owed by earlier prints.
   row_word_type      expected_rows[$];
   logic [BITS_W-1:0] canvas_image [GRID_N];
   logic              pen_lowered;
   logic [1:0]        pen_heading;
   logic [POS_W-1:0]  pen_row;
   logic [POS_W-1:0]  pen_col;

   initial begin
      mismatch_count = 0;
      rows_pending   = 0;
   end

   // Print one line for a mismatch and count it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Walk the pen up to move_len cells, stopping at the grid edge.
   function automatic void walk_pen(input logic [DIST_W-1:0] move_len);
      int room;
      int steps;
      case (pen_heading)
         HEAD_RIGHT: room = GRID_N - 1 - int'(pen_col);
         HEAD_DOWN:  room = GRID_N - 1 - int'(pen_row);
         HEAD_LEFT:  room = int'(pen_col);
         default:    room = int'(pen_row);
      endcase
      steps = (int'(move_len) < room) ? int'(move_len) : room;
      for (int k = 0; k < steps; k++) begin
         case (pen_heading)
            HEAD_RIGHT: pen_col = pen_col + POS_W'(1);
            HEAD_DOWN:  pen_row = pen_row + POS_W'(1);
            HEAD_LEFT:  pen_col = pen_col - POS_W'(1);
            default:    pen_row = pen_row - POS_W'(1);
         endcase
         if (pen_lowered) begin
            canvas_image[pen_row][pen_col] = 1'b1;
         end
      end
   endfunction

   // Apply one command to the predicted state and queue any rows it prints.
   function automatic void apply_plot_command(input logic [KIND_W-1:0] kind,
                                              input logic [DIST_W-1:0] move_len);
      row_word_type word;
      case (kind)
         KIND_PEN_UP:   pen_lowered = 1'b0;
         KIND_PEN_DOWN: pen_lowered = 1'b1;
         KIND_TURN_RGT: pen_heading = pen_heading + 2'd1;
         KIND_TURN_LFT: pen_heading = pen_heading + HEAD_TURN_LFT;
         KIND_MOVE:     walk_pen(move_len);
         KIND_PRINT: begin
            for (int r = 0; r < GRID_N; r++) begin
               word.row_index = r[POS_W-1:0];
               word.row_bits  = canvas_image[r];
               word.last_row  = (r == GRID_N - 1);
               expected_rows.push_back(word);
            end
         end
         default: ;
      endcase
   endfunction

   // Compare finished row transactions first, then predict from accepted commands.
   always @(posedge clock) begin
      row_word_type want;
      if (reset) begin
         expected_rows.delete();
         for (int r = 0; r < GRID_N; r++) begin
            canvas_image[r] = '0;
         end
         pen_lowered = 1'b0;
         pen_heading = HEAD_RIGHT;
         pen_row     = '0;
         pen_col     = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("unexpected row transaction, row_index", rsp_row_index, 0);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_row_index !== want.row_index) begin
                  report_mismatch("row_index", rsp_row_index, want.row_index);
               end
               if (rsp_row_bits !== want.row_bits) begin
                  report_mismatch("row_bits", rsp_row_bits, want.row_bits);
               end
               if (rsp_last_row !== want.last_row) begin
                  report_mismatch("last_row", rsp_last_row, want.last_row);
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_plot_command(req_kind, req_distance);
         end
      end
      rows_pending = expected_rows.size();
   end

endmodule

FILE: tb/sv/turtle_pen_raster_plotter_test.sv
// Testbench top for the turtle pen raster plotter: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module turtle_pen_raster_plotter_test;

   import tprp_pkg::*;

   localparam int GRID_SIZE        = 32;
   localparam int RANDOM_COMMANDS  = 112;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 40;

   // Command codes the block does not use; it must ignore them.
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = KIND_PEN_UP;
   logic [DIST_W-1:0] req_distance = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [POS_W-1:0]  rsp_row_index;
   logic [BITS_W-1:0] rsp_row_bits;
   logic              rsp_last_row;

   int mismatch_count;
   int rows_pending;

   // Pacing controls of the sender and the receiver.
   logic quiet_mode = 1'b0;
   logic burst_mode = 1'b0;
   logic long_hold  = 1'b0;

   always #5 clock = ~clock;

   turtle_pen_raster_plotter #(
      .GRID_SIZE(GRID_SIZE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_distance(req_distance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_row_index(rsp_row_index),
      .rsp_row_bits(rsp_row_bits),
      .rsp_last_row(rsp_last_row)
   );

   turtle_pen_plot_checker #(
      .GRID_SIZE(GRID_SIZE)
   ) plot_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_distance(req_distance),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_row_index(rsp_row_index),
      .rsp_row_bits(rsp_row_bits),
      .rsp_last_row(rsp_last_row),
      .mismatch_count(mismatch_count),
      .rows_pending(rows_pending)
   );

   // Offer one command transaction after a random gap (none in quiet or burst mode) and hold it until accepted.
   // Called and returns at a falling edge.
   task automatic send_command(input logic [KIND_W-1:0] kind,
                               input logic [DIST_W-1:0] move_len);
      int unsigned gap;
      gap = (quiet_mode || burst_mode) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_distance <= move_len;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stop offering commands and wait at falling edges until every predicted row
   // has come out.
   task automatic wait_for_rows();
      req_valid <= 1'b0;
      do @(negedge clock); while (rows_pending != 0);
   endtask

   // Receiver: random stall before each row transaction (none in quiet mode), with one long hold-off on request.
   initial begin : row_receiver
      int unsigned hold_cycles;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold   = 1'b0;
            hold_cycles = LONG_HOLD_CYCLES;
         end else begin
            hold_cycles = quiet_mode ? 0 : $urandom_range(0, 7);
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Stimulus: reset, directed commands, then random commands in several phases.
   initial begin : command_stimulus
      int unsigned pick;
      logic [KIND_W-1:0] kind;
      logic [DIST_W-1:0] move_len;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Blank canvas right after reset, then unused codes.
      send_command(KIND_PRINT, 8'd0);
      send_command(KIND_SPARE_LO, 8'd255);
      send_command(KIND_SPARE_HI, 8'd0);
      // Zero distance with the pen down, then runs to each edge.
      send_command(KIND_PEN_DOWN, 8'd0);
      send_command(KIND_MOVE, 8'd0);
      send_command(KIND_MOVE, 8'd255);
      send_command(KIND_TURN_RGT, 8'd0);
      send_command(KIND_MOVE, 8'd170);
      send_command(KIND_TURN_RGT, 8'd0);
      // A pen-up move shifts the position without marking.
      send_command(KIND_PEN_UP, 8'd0);
      send_command(KIND_MOVE, 8'd5);
      send_command(KIND_PEN_DOWN, 8'd0);
      send_command(KIND_MOVE, 8'd85);
      // Left turns wrap the heading around through right to up.
      send_command(KIND_TURN_LFT, 8'd0);
      send_command(KIND_TURN_LFT, 8'd0);
      send_command(KIND_TURN_LFT, 8'd0);
      send_command(KIND_MOVE, 8'd255);
      send_command(KIND_TURN_RGT, 8'd0);
      send_command(KIND_PRINT, 8'd0);

      for (int i = 0; i < RANDOM_COMMANDS; i++) begin
         // Back-pressure phase: the receiver holds off while prints keep coming.
         if (i == 40) begin
            long_hold  = 1'b1;
            burst_mode = 1'b1;
         end
         if (i == 48) begin
            burst_mode = 1'b0;
         end
         // The sender pauses until all printed rows are out.
         if (i == 70) begin
            wait_for_rows();
         end
         quiet_mode = (i >= 90 && i < 110);

         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            kind = KIND_PEN_UP;
         end else if (pick < 25) begin
            kind = KIND_PEN_DOWN;
         end else if (pick < 38) begin
            kind = KIND_TURN_RGT;
         end else if (pick < 50) begin
            kind = KIND_TURN_LFT;
         end else if (pick < 85) begin
            kind = KIND_MOVE;
         end else if (pick < 95) begin
            kind = KIND_PRINT;
         end else begin
            kind = (pick[0]) ? KIND_SPARE_HI : KIND_SPARE_LO;
         end
         if (burst_mode) begin
            kind = KIND_PRINT;
         end
         // Mostly short moves so the pen wanders; some long ones hit the edges.
         if ($urandom_range(0, 9) < 7) begin
            move_len = DIST_W'($urandom_range(0, 8));
         end else begin
            move_len = DIST_W'($urandom_range(0, 255));
         end
         send_command(kind, move_len);
      end

      // Drain the remaining rows, then give the verdict.
      quiet_mode = 1'b0;
      wait_for_rows();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tprp_pkg.sv
hw/rtl/tprp_canvas.sv
hw/rtl/turtle_pen_raster_plotter.sv
tb/sv/turtle_pen_plot_checker.sv
tb/sv/turtle_pen_raster_plotter_test.sv
